FILE: rtl/nkhc_pkg.sv
// ---------------------------------------------------------------------------
// nkhc_pkg
// Shared types and constants of the name-keyed handle cache.
// ---------------------------------------------------------------------------
`default_nettype none

package nkhc_pkg;

    localparam int ENTRIES     = 8;
    localparam int NAME_BYTES  = 32;
    localparam int IN_BYTES    = 31;
    localparam int IN_BITS     = 8 * IN_BYTES;
    localparam int STORE_BYTES = NAME_BYTES - 1;
    localparam int KEY_BITS    = 8 * STORE_BYTES;
    localparam int PTR_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HANDLE_W    = 32;

    typedef enum logic [1:0] {
        KIND_LOOKUP    = 2'd0,
        KIND_CLEAR_ONE = 2'd1,
        KIND_CLEAR_ALL = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIPE,
        ST_START,
        ST_WAIT,
        ST_RESOLVE
    } state_t;

    // Probe word handed from cell to cell.
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [HANDLE_W-1:0] handle;
    } token_t;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic clear_all;
        logic lookup;
        logic key_ok;
    } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/nkhc_cell.sv
// ---------------------------------------------------------------------------
// nkhc_cell
// One cache entry: stored name and handle, compared against the probe word
// as it passes and handed on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module nkhc_cell (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire nkhc_pkg::ctl_t                   ctl,
    input  wire logic [nkhc_pkg::KEY_BITS-1:0]    key,
    input  wire logic                             fill_en,
    input  wire logic [nkhc_pkg::HANDLE_W-1:0]    fill_handle,
    input  wire nkhc_pkg::token_t                 tok_in,
    output nkhc_pkg::token_t                      tok_out
);

    logic [nkhc_pkg::KEY_BITS-1:0] key_reg;
    logic [nkhc_pkg::KEY_BITS-1:0] key_next;
    logic [nkhc_pkg::HANDLE_W-1:0] handle_reg;
    logic [nkhc_pkg::HANDLE_W-1:0] handle_next;
    nkhc_pkg::token_t              tok_reg;
    nkhc_pkg::token_t              tok_next;
    logic                          used;
    logic                          take;

    assign used = (key_reg[7:0] != 8'd0);
    assign take = tok_in.valid && !tok_in.found && ctl.key_ok && (key_reg == key)
                  && (used || !ctl.lookup);

    always_comb
    begin
        tok_next.valid  = tok_in.valid;
        tok_next.found  = tok_in.found | take;
        tok_next.handle = take ? handle_reg : tok_in.handle;
    end

    // Wipe beats fill beats a named clear.
    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctl.clear_all)
        begin
            key_next    = '0;
            handle_next = '0;
        end
        else if (fill_en)
        begin
            key_next    = key;
            handle_next = fill_handle;
        end
        else if (take && !ctl.lookup)
        begin
            key_next    = '0;
            handle_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            handle_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            key_reg    <= key_next;
            handle_reg <= handle_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: rtl/name_keyed_handle_cache_top.sv
// ---------------------------------------------------------------------------
// name_keyed_handle_cache_top
// Eight-entry fully associative name-to-handle cache with round-robin fill.
// Lookup: the probe walks the cell chain one cell per cycle; its end word is
//   captured and then loaded into the output register as the result.
// Input: a new word is taken only in the idle state, so lookups and named
//   clears hold it off until the scan ends, lookups also while a held result
//   waits on out_stall; clear-all holds it off for its wipe, and an unknown kind is ignored.
// Reset: every entry empty, handles zero, fill pointer zero, no result held.
// ---------------------------------------------------------------------------
`default_nettype none

module name_keyed_handle_cache_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       kind,
    input  wire logic [63:0]                      key_word0,
    input  wire logic [63:0]                      key_word1,
    input  wire logic [63:0]                      key_word2,
    input  wire logic [55:0]                      key_word3,
    input  wire logic                             resolved_valid,
    input  wire logic [nkhc_pkg::HANDLE_W-1:0]    resolved_handle,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [nkhc_pkg::HANDLE_W-1:0]         handle_out,
    output logic                                  handle_valid,
    output logic                                  hit
);

    // Input word registers: the normalized key stays put for the whole scan,
    // so the cells compare against it directly and only the probe moves.
    logic [1:0]                    kind_reg;
    logic [nkhc_pkg::KEY_BITS-1:0] key_reg;
    logic                          key_ok_reg;
    logic                          rv_reg;
    logic [nkhc_pkg::HANDLE_W-1:0] rh_reg;

    logic [nkhc_pkg::PTR_W-1:0]    ptr_reg;
    logic [nkhc_pkg::PTR_W-1:0]    ptr_next;
    nkhc_pkg::state_t              state_reg;
    nkhc_pkg::state_t              state_next;
    nkhc_pkg::token_t              end_reg;

    logic [nkhc_pkg::HANDLE_W-1:0] out_handle_reg;
    logic                          out_hv_reg;
    logic                          out_hit_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    // FSM outputs
    logic                          accept;
    logic                          inject;
    logic                          do_wipe;
    logic                          do_fill;
    logic                          load_out;
    logic                          capture_end;
    logic                          out_free;
    logic                          is_lookup;

    // Name normalization
    logic [nkhc_pkg::IN_BITS-1:0]  raw_key;
    logic [nkhc_pkg::IN_BITS-1:0]  norm_key;
    logic [nkhc_pkg::IN_BYTES-1:0] byte_nz;
    logic [nkhc_pkg::IN_BYTES-1:0] byte_keep;
    logic                          norm_ok;

    nkhc_pkg::token_t              tok [nkhc_pkg::ENTRIES+1];
    logic [nkhc_pkg::ENTRIES-1:0]  fill_sel;
    nkhc_pkg::ctl_t                ctl;

    assign raw_key = {key_word3, key_word2, key_word1, key_word0};

    // Keep a byte only while every byte before it is non-zero: the name ends
    // at its first zero byte and anything after it is ignored.
    always_comb
    begin
        for (int i = 0; i < nkhc_pkg::IN_BYTES; i++)
        begin
            byte_nz[i] = (raw_key[8*i +: 8] != 8'd0);
        end
        for (int i = 0; i < nkhc_pkg::IN_BYTES; i++)
        begin
            byte_keep[i] = &(byte_nz | ({nkhc_pkg::IN_BYTES{1'b1}} << i));
            norm_key[8*i +: 8] = byte_keep[i] ? raw_key[8*i +: 8] : 8'd0;
        end
    end

    // A name longer than an entry holds can never match a stored entry.
    assign norm_ok = ((norm_key >> nkhc_pkg::KEY_BITS) == '0);

    assign accept    = in_valid && !in_stall;
    assign is_lookup = (kind_reg == nkhc_pkg::KIND_LOOKUP);
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nkhc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind) inside
                        nkhc_pkg::KIND_LOOKUP,
                        nkhc_pkg::KIND_CLEAR_ONE: state_next = nkhc_pkg::ST_START;
                        nkhc_pkg::KIND_CLEAR_ALL: state_next = nkhc_pkg::ST_WIPE;
                        default:                  state_next = nkhc_pkg::ST_IDLE;
                    endcase
                end
            end
            nkhc_pkg::ST_WIPE:  state_next = nkhc_pkg::ST_IDLE;
            nkhc_pkg::ST_START: state_next = nkhc_pkg::ST_WAIT;
            nkhc_pkg::ST_WAIT:
            begin
                if (tok[nkhc_pkg::ENTRIES].valid)
                begin
                    state_next = nkhc_pkg::ST_RESOLVE;
                end
            end
            nkhc_pkg::ST_RESOLVE:
            begin
                if (!is_lookup || out_free)
                begin
                    state_next = nkhc_pkg::ST_IDLE;
                end
            end
            default:            state_next = nkhc_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall    = 1'b1;
        inject      = 1'b0;
        do_wipe     = 1'b0;
        do_fill     = 1'b0;
        load_out    = 1'b0;
        capture_end = 1'b0;
        unique case (state_reg)
            nkhc_pkg::ST_IDLE:    in_stall = 1'b0;
            nkhc_pkg::ST_WIPE:    do_wipe  = 1'b1;
            nkhc_pkg::ST_START:   inject   = 1'b1;
            nkhc_pkg::ST_WAIT:    capture_end = tok[nkhc_pkg::ENTRIES].valid;
            nkhc_pkg::ST_RESOLVE:
            begin
                load_out = is_lookup && out_free;
                do_fill  = load_out && !end_reg.found && rv_reg;
            end
            default:              in_stall = 1'b1;
        endcase
    end

    // Advance the fill pointer round robin, wrap at the last entry; a wipe resets it to zero.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (do_wipe)
        begin
            ptr_next = '0;
        end
        else if (do_fill)
        begin
            if (ptr_reg == nkhc_pkg::PTR_W'(nkhc_pkg::ENTRIES - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    // Drop the held result when taken, load a new one when the slot frees.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nkhc_pkg::ST_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            key_reg    <= norm_key[nkhc_pkg::KEY_BITS-1:0];
            key_ok_reg <= norm_ok;
            rv_reg     <= resolved_valid;
            rh_reg     <= resolved_handle;
        end
        if (capture_end)
        begin
            end_reg <= tok[nkhc_pkg::ENTRIES];
        end
        if (load_out)
        begin
            // Hit: cached handle. Miss: resolver's handle, or zero if it missed.
            if (end_reg.found)
            begin
                out_handle_reg <= end_reg.handle;
                out_hv_reg     <= 1'b1;
                out_hit_reg    <= 1'b1;
            end
            else
            begin
                out_handle_reg <= rv_reg ? rh_reg : '0;
                out_hv_reg     <= rv_reg;
                out_hit_reg    <= 1'b0;
            end
        end
    end

    // Launch one probe word into the head of the chain.
    assign tok[0] = '{valid: inject, found: 1'b0, handle: '0};

    always_comb
    begin
        ctl.clear_all = do_wipe;
        ctl.lookup    = is_lookup;
        ctl.key_ok    = key_ok_reg;
    end

    for (genvar g = 0; g < nkhc_pkg::ENTRIES; g++)
    begin : g_cell
        assign fill_sel[g] = do_fill && (ptr_reg == nkhc_pkg::PTR_W'(g));

        nkhc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (key_reg),
            .fill_en     (fill_sel[g]),
            .fill_handle (rh_reg),
            .tok_in      (tok[g]),
            .tok_out     (tok[g+1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign handle_out   = out_handle_reg;
    assign handle_valid = out_hv_reg;
    assign hit          = out_hit_reg;

endmodule

`default_nettype wire
